### rtl/pwns_pkg.sv
package pwns_pkg;

   localparam int CMD_W          = 2;
   localparam int IDX_W          = 10;
   localparam int COORD_W        = 24;
   localparam int DIST_W         = 24;
   localparam int COUNT_W        = 11;
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_COORD_BITS = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD      = 2'd0,
      CMD_NEAREST   = 2'd1,
      CMD_LOOKAHEAD = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic [IDX_W-1:0]           slot_index;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic [DIST_W-1:0]          path_distance;
      logic [DIST_W-1:0]          distance_limit;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] result_index;
   } rsp_type;

endpackage

### rtl/pwns_point_mem.sv
module pwns_point_mem #(
   parameter int DEPTH = pwns_pkg::DEF_MAX_POINTS,
   parameter int AW    = $clog2(pwns_pkg::DEF_MAX_POINTS),
   parameter int MW    = 2 * pwns_pkg::DEF_COORD_BITS + pwns_pkg::DIST_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [MW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [MW-1:0] rd_data
);

   logic [MW-1:0] mem_ff [DEPTH];
   logic [MW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pwns_sq_dist.sv
module pwns_sq_dist #(
   parameter int COORD_BITS = pwns_pkg::DEF_COORD_BITS,
   parameter int IW         = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] x,
   input  logic signed [COORD_BITS-1:0] y,
   input  logic [IW-1:0]                in_idx,
   output logic                         out_valid,
   output logic [2*(COORD_BITS+1):0]    out_sq,
   output logic [IW-1:0]                out_idx,
   output logic                         busy
);

   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int SQ_W = PW + 1;

   logic signed [DW-1:0] ddx, ddy;
   logic [DW-1:0]        adx_in, ady_in;
   logic [DW-1:0]        adx_ff, ady_ff;
   logic [PW-1:0]        pxx_ff, pyy_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [IW-1:0]        idxa_ff, idxb_ff, idxc_ff;
   logic                 va_ff, vb_ff, vc_ff;

   assign ddx    = DW'(px) - DW'(x);
   assign ddy    = DW'(py) - DW'(y);
   assign adx_in = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
   assign ady_in = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
      idxa_ff <= in_idx;
      pxx_ff  <= adx_ff * adx_ff;
      pyy_ff  <= ady_ff * ady_ff;
      idxb_ff <= idxa_ff;
      sq_ff   <= SQ_W'(pxx_ff) + SQ_W'(pyy_ff);
      idxc_ff <= idxb_ff;
   end

   assign out_valid = vc_ff;
   assign out_sq    = sq_ff;
   assign out_idx   = idxc_ff;
   assign busy      = va_ff | vb_ff | vc_ff;

endmodule

### rtl/pwns_search_ctrl.sv
module pwns_search_ctrl #(
   parameter int MAX_POINTS = pwns_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = pwns_pkg::DEF_COORD_BITS,
   parameter int AW         = $clog2(pwns_pkg::DEF_MAX_POINTS),
   parameter int CW         = 12,
   parameter int MW         = 2 * pwns_pkg::DEF_COORD_BITS + pwns_pkg::DIST_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pwns_pkg::req_type                 req,
   input  logic [pwns_pkg::COUNT_W-1:0]      point_count,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [MW-1:0]                     wr_data,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  logic [MW-1:0]                     rd_data,
   output logic                              du_in_valid,
   output logic signed [COORD_BITS-1:0]      du_px,
   output logic signed [COORD_BITS-1:0]      du_py,
   output logic signed [COORD_BITS-1:0]      du_x,
   output logic signed [COORD_BITS-1:0]      du_y,
   output logic [CW-1:0]                     du_in_idx,
   input  logic                              du_valid,
   input  logic [2*(COORD_BITS+1):0]         du_sq,
   input  logic [CW-1:0]                     du_idx,
   input  logic                              du_busy,
   output logic                              res_valid,
   input  logic                              res_ready,
   output pwns_pkg::rsp_type                 res
);

   localparam int DIST_W = pwns_pkg::DIST_W;
   localparam int IDX_W  = pwns_pkg::IDX_W;
   localparam int SQ_W   = 2 * (COORD_BITS + 1) + 1;
   localparam logic [CW-1:0] MAX_CW = CW'(MAX_POINTS);

   pwns_pkg::state_type state_ff, state_in;
   pwns_pkg::cmd_type   cmd_ff;
   pwns_pkg::rsp_type   res_ff, imm_rsp, scan_rsp;

   logic                         accept, start_scan, scan_end;
   logic [CW-1:0]                pc_cw, n_cur, n_minus, slot_cw;
   logic signed [31:0]           cx32, cy32;
   logic signed [COORD_BITS-1:0] cx_cb, cy_cb;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [DIST_W-1:0]            lim_ff, base_ff;
   logic [CW-1:0]                last_ff, issue_ff, idx1_ff, best_idx_ff, hit_idx_ff;
   logic                         issue_done_ff, first_issue_ff, v1_ff, first1_ff;
   logic                         stop_ff, have_ff, hit_ff, last_ok_ff;
   logic [SQ_W-1:0]              best_ff;

   logic [DIST_W-1:0]            rd_dist, base_eff, gap;
   logic                         beat, over, stop_hit, la_hit, best_upd;

   assign accept  = req_valid & req_ready;
   assign pc_cw   = CW'(point_count);
   assign n_cur   = (pc_cw > MAX_CW) ? MAX_CW : pc_cw;
   assign n_minus = n_cur - CW'(1);
   assign slot_cw = CW'(req.slot_index);
   assign cx32    = 32'(req.coord_x);
   assign cy32    = 32'(req.coord_y);
   assign cx_cb   = cx32[COORD_BITS-1:0];
   assign cy_cb   = cy32[COORD_BITS-1:0];

   assign start_scan = ((req.cmd == pwns_pkg::CMD_NEAREST) ||
                        (req.cmd == pwns_pkg::CMD_LOOKAHEAD)) &&
                       (n_cur != '0) && (slot_cw < n_cur);

   // result when no scan runs (load, other command, start past end or empty table), settled at accept
   always_comb begin
      imm_rsp = '0;
      case (req.cmd)
         pwns_pkg::CMD_NEAREST: begin
            if (n_cur != '0) begin
               imm_rsp.found        = 1'b1;
               imm_rsp.result_index = n_minus[IDX_W-1:0];
            end
         end
         default: imm_rsp = '0;
      endcase
   end

   assign wr_addr = slot_cw[AW-1:0];
   assign wr_data = {cx_cb, cy_cb, req.path_distance};

   // data stage
   assign rd_dist  = rd_data[DIST_W-1:0];
   assign du_x     = rd_data[MW-1 -: COORD_BITS];
   assign du_y     = rd_data[DIST_W +: COORD_BITS];
   assign base_eff = first1_ff ? rd_dist : base_ff;
   assign gap      = (base_eff >= rd_dist) ? base_eff - rd_dist : rd_dist - base_eff;
   assign over     = gap > lim_ff;
   assign beat     = v1_ff & ~stop_ff;
   assign stop_hit = beat & over & (cmd_ff == pwns_pkg::CMD_NEAREST);
   assign la_hit   = beat & over & ~hit_ff & (cmd_ff == pwns_pkg::CMD_LOOKAHEAD);

   assign du_in_valid = beat & ~over & (cmd_ff == pwns_pkg::CMD_NEAREST);
   assign du_px       = px_ff;
   assign du_py       = py_ff;
   assign du_in_idx   = idx1_ff;

   assign best_upd = du_valid & (~have_ff | (du_sq < best_ff));
   assign scan_end = issue_done_ff & ~v1_ff & ~du_busy;

   always_comb begin
      scan_rsp       = '0;
      scan_rsp.found = 1'b1;
      if (cmd_ff == pwns_pkg::CMD_NEAREST) begin
         scan_rsp.result_index = best_idx_ff[IDX_W-1:0];
      end else if (!last_ok_ff && hit_ff) begin
         scan_rsp.result_index = hit_idx_ff[IDX_W-1:0];
      end else begin
         scan_rsp.result_index = last_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwns_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = start_scan ? pwns_pkg::ST_SCAN : pwns_pkg::ST_DONE;
            end
         end
         pwns_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = pwns_pkg::ST_DONE;
            end
         end
         pwns_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = pwns_pkg::ST_IDLE;
            end
         end
         default: state_in = pwns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == pwns_pkg::ST_IDLE);
      rd_en     = (state_ff == pwns_pkg::ST_SCAN) & ~issue_done_ff;
      rd_addr   = issue_ff[AW-1:0];
      res_valid = (state_ff == pwns_pkg::ST_DONE);
      wr_en     = accept & (req.cmd == pwns_pkg::CMD_LOAD) & (slot_cw < MAX_CW);
      res       = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pwns_pkg::ST_IDLE;
         v1_ff          <= 1'b0;
         issue_done_ff  <= 1'b1;
         first_issue_ff <= 1'b0;
         stop_ff        <= 1'b0;
         have_ff        <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         if (accept) begin
            issue_done_ff  <= ~start_scan;
            first_issue_ff <= 1'b1;
            stop_ff        <= 1'b0;
            have_ff        <= 1'b0;
            hit_ff         <= 1'b0;
         end else begin
            if (rd_en) begin
               first_issue_ff <= 1'b0;
            end
            if (stop_hit || (rd_en && (issue_ff == last_ff))) begin
               issue_done_ff <= 1'b1;
            end
            if (stop_hit) begin
               stop_ff <= 1'b1;
            end
            if (best_upd) begin
               have_ff <= 1'b1;
            end
            if (la_hit) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req.cmd;
         px_ff    <= cx_cb;
         py_ff    <= cy_cb;
         lim_ff   <= req.distance_limit;
         last_ff  <= n_minus;
         issue_ff <= slot_cw;
         res_ff   <= imm_rsp;
      end
      if (rd_en) begin
         issue_ff  <= issue_ff + CW'(1);
         idx1_ff   <= issue_ff;
         first1_ff <= first_issue_ff;
      end
      if (beat && first1_ff) begin
         base_ff <= rd_dist;
      end
      if (best_upd) begin
         best_ff     <= du_sq;
         best_idx_ff <= du_idx;
      end
      if (la_hit) begin
         hit_idx_ff <= idx1_ff;
      end
      if (beat && (idx1_ff == last_ff) && (cmd_ff == pwns_pkg::CMD_LOOKAHEAD)) begin
         last_ok_ff <= ~over;
      end
      if ((state_ff == pwns_pkg::ST_SCAN) && scan_end) begin
         res_ff <= scan_rsp;
      end
   end

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff <= last_ff))
      else $error("read issued past last point");

   a_du_in_scan: assert property (@(posedge clock) disable iff (reset)
      du_valid |-> (state_ff == pwns_pkg::ST_SCAN))
      else $error("distance result outside scan");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pwns_pkg::ST_DONE) && !res_ready) |=>
         ((state_ff == pwns_pkg::ST_DONE) && $stable(res_ff)))
      else $error("result dropped while stalled");

   a_nearest_has_best: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pwns_pkg::ST_SCAN) && scan_end &&
       (cmd_ff == pwns_pkg::CMD_NEAREST)) |-> have_ff)
      else $error("nearest scan ended with no candidate");

endmodule

### rtl/path_window_nearest_search.sv
// Path closest-point and lookahead search.
// Input channel req_valid/req_ready/req_payload carries one command per transfer:
// load a point into a slot, a nearest search or a lookahead search. The result
// channel rsp_valid/rsp_ready/rsp_payload returns exactly one result per command
// (found, result_index), in order. csr_wr_en/csr_wr_data set point_count; write
// it only while no command is outstanding.
// One command is processed at a time. Loads, unknown commands and searches that
// need no scan raise rsp_valid through the DONE state and the output register. A
// search reads the point memory one entry per cycle from its start index; the
// single read port sets that rate. A lookahead search reads to the last point.
// A nearest search sends each point inside the window through a 3-stage
// squared-distance pipeline and stops at the first point outside it. At the
// earliest, the next command transfers in the cycle that rsp_valid rises.
// A finished result sits in the output register; the next command is taken
// while it waits, and is held in its final state until the slot frees.
// Reset (synchronous) clears point_count and control; the point memory is not
// cleared and must be loaded before it is searched.
module path_window_nearest_search #(
   parameter int MAX_POINTS = pwns_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = pwns_pkg::DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pwns_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pwns_pkg::rsp_type            rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [pwns_pkg::COUNT_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = ((AW > pwns_pkg::COUNT_W) ? AW : pwns_pkg::COUNT_W) + 1;
   localparam int MW = 2 * COORD_BITS + pwns_pkg::DIST_W;

   logic [pwns_pkg::COUNT_W-1:0] count_ff;
   logic                         rsp_valid_ff;
   pwns_pkg::rsp_type            rsp_ff, res;
   logic                         res_valid, res_ready;

   logic                         wr_en, rd_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [MW-1:0]                wr_data, rd_data;

   logic                         du_in_valid, du_valid, du_busy;
   logic signed [COORD_BITS-1:0] du_px, du_py, du_x, du_y;
   logic [CW-1:0]                du_in_idx, du_idx;
   logic [2*(COORD_BITS+1):0]    du_sq;

   pwns_point_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (AW),
      .MW    (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pwns_sq_dist #(
      .COORD_BITS (COORD_BITS),
      .IW         (CW)
   ) u_sq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (du_in_valid),
      .px        (du_px),
      .py        (du_py),
      .x         (du_x),
      .y         (du_y),
      .in_idx    (du_in_idx),
      .out_valid (du_valid),
      .out_sq    (du_sq),
      .out_idx   (du_idx),
      .busy      (du_busy)
   );

   pwns_search_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .AW         (AW),
      .CW         (CW),
      .MW         (MW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req_payload),
      .point_count (count_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .du_in_valid (du_in_valid),
      .du_px       (du_px),
      .du_py       (du_py),
      .du_x        (du_x),
      .du_y        (du_y),
      .du_in_idx   (du_in_idx),
      .du_valid    (du_valid),
      .du_sq       (du_sq),
      .du_idx      (du_idx),
      .du_busy     (du_busy),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign res_ready = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
